/* rtl/tqi_pkg.sv */
`default_nettype none
package tqi_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned STATUS_W = 2;

   // action codes on the request channel
   localparam logic [ACTION_W-1:0] ACT_PUSH_A = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_B = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MERGE  = 2'd2;

   // status codes on the response channel
   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ITEM     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

   typedef enum logic [1:0] {
      FSM_IDLE  = 2'b01,
      FSM_MERGE = 2'b10
   } fsm_state_type;

   // controller to datapath
   typedef struct packed {
      logic push_a;
      logic push_b;
      logic merge_start;
      logic merge_step;
      logic report_empty;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic both_empty;
      logic merge_last;
   } dp_stat_type;

endpackage
`default_nettype wire

/* rtl/tqi_ctrl.sv */
`default_nettype none
module tqi_ctrl
   import tqi_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [ACTION_W-1:0] req_action,
   output      logic                req_stall,
   input  wire dp_stat_type         stat,
   output      dp_cmd_type          cmd
);

   fsm_state_type state_ff, state_in;
   logic          accepted;

   assign req_stall = (state_ff != FSM_IDLE) || !stat.out_free;
   assign accepted  = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accepted) begin
               cmd.push_a = (req_action == ACT_PUSH_A);
               cmd.push_b = (req_action == ACT_PUSH_B);
               if (req_action == ACT_MERGE) begin
                  if (stat.both_empty) begin
                     cmd.report_empty = 1'b1;
                  end else begin
                     cmd.merge_start = 1'b1;
                     state_in        = FSM_MERGE;
                  end
               end
            end
         end
         FSM_MERGE: begin
            if (stat.out_free) begin
               cmd.merge_step = 1'b1;
               if (stat.merge_last) begin
                  state_in = FSM_IDLE;
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/tqi_datapath.sv */
`default_nettype none
module tqi_datapath
   import tqi_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dp_cmd_type               cmd,
   input  wire logic signed [WORD_W-1:0] req_value,
   input  wire logic                     rsp_stall,
   output      dp_stat_type              stat,
   output      logic                     rsp_valid,
   output      logic [STATUS_W-1:0]      rsp_status,
   output      logic signed [WORD_W-1:0] rsp_item,
   output      logic                     rsp_last
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WORD_W-1:0] store_a [DEPTH];
   logic [WORD_W-1:0] store_b [DEPTH];

   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;
   logic [CNT_W-1:0] rd_a_ff, rd_a_in;
   logic [CNT_W-1:0] rd_b_ff, rd_b_in;
   logic             turn_b_ff, turn_b_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]   rsp_item_ff, rsp_item_in;
   logic                rsp_last_ff, rsp_last_in;

   logic             full_a, full_b, a_left, b_left, take_a, load;
   logic [CNT_W-1:0] rd_a_inc, rd_b_inc;

   assign full_a   = (count_a_ff == FULL_CNT);
   assign full_b   = (count_b_ff == FULL_CNT);
   assign a_left   = (rd_a_ff < count_a_ff);
   assign b_left   = (rd_b_ff < count_b_ff);
   // a's turn unless a is drained, or b's turn while b still has words
   assign take_a   = (!turn_b_ff && a_left) || !b_left;
   assign rd_a_inc = rd_a_ff + CNT_W'(1);
   assign rd_b_inc = rd_b_ff + CNT_W'(1);

   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;
   assign stat.both_empty = (count_a_ff == '0) && (count_b_ff == '0);
   assign stat.merge_last = take_a ? ((rd_a_inc == count_a_ff) && !b_left)
                                   : ((rd_b_inc == count_b_ff) && !a_left);

   assign load = cmd.push_a || cmd.push_b || cmd.report_empty || cmd.merge_step;

   always_ff @(posedge clock) begin
      if (cmd.push_a && !full_a) begin
         store_a[count_a_ff[IDX_W-1:0]] <= req_value;
      end
      if (cmd.push_b && !full_b) begin
         store_b[count_b_ff[IDX_W-1:0]] <= req_value;
      end
   end

   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      rd_a_in    = rd_a_ff;
      rd_b_in    = rd_b_ff;
      turn_b_in  = turn_b_ff;
      if (cmd.push_a && !full_a) begin
         count_a_in = count_a_ff + CNT_W'(1);
      end
      if (cmd.push_b && !full_b) begin
         count_b_in = count_b_ff + CNT_W'(1);
      end
      if (cmd.merge_start) begin
         rd_a_in   = '0;
         rd_b_in   = '0;
         turn_b_in = 1'b0;
      end
      if (cmd.merge_step) begin
         if (take_a) begin
            rd_a_in   = rd_a_inc;
            turn_b_in = 1'b1;
         end else begin
            rd_b_in   = rd_b_inc;
            turn_b_in = 1'b0;
         end
         if (stat.merge_last) begin
            count_a_in = '0;
            count_b_in = '0;
         end
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = '0;
         rsp_last_in  = 1'b1;
         priority if (cmd.merge_step) begin
            rsp_status_in = ST_ITEM;
            rsp_last_in   = stat.merge_last;
         end else if (cmd.report_empty) begin
            rsp_status_in = ST_EMPTY;
         end else if (cmd.push_a) begin
            rsp_status_in = full_a ? ST_FULL : ST_ACCEPTED;
         end else begin
            rsp_status_in = full_b ? ST_FULL : ST_ACCEPTED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         rd_a_ff      <= '0;
         rd_b_ff      <= '0;
         turn_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         rd_a_ff      <= rd_a_in;
         rd_b_ff      <= rd_b_in;
         turn_b_ff    <= turn_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // drained words are read straight into the response register
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      if (cmd.merge_step) begin
         if (take_a) begin
            rsp_item_ff <= store_a[rd_a_ff[IDX_W-1:0]];
         end else begin
            rsp_item_ff <= store_b[rd_b_ff[IDX_W-1:0]];
         end
      end else begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_item   = rsp_item_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
`default_nettype wire

/* rtl/two_queue_interleaver.sv */
`default_nettype none
// two bounded queues, a and b, of DEPTH signed words each. action 0 or 1 pushes
// req_value onto a or b and answers with one transfer: status accepted, or full
// when that queue already holds DEPTH words (the queue is left unchanged). action 2
// drains both queues alternately starting with a, one word per response
// transfer, the final one marked by rsp_last; both queues are then empty. a merge
// on two empty queues answers with a single transfer of status empty. action 3 is
// dropped with no response. item is zero on every status other than merged item.
// timing: the response to a push or an empty merge is registered from the request
// transfer. a merge first decodes and resets the drain pointers, then drains one
// word per step, count_a + count_b in all (at most 2*DEPTH), set by the single
// read port of each queue store; the request side is stalled for the whole drain.
// a new request is taken while a response still waits in the output register,
// as long as that register is being emptied in the same cycle.
module two_queue_interleaver
   import tqi_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [ACTION_W-1:0]      req_action,
   input  wire logic signed [WORD_W-1:0] req_value,
   // response channel
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [STATUS_W-1:0]      rsp_status,
   output      logic signed [WORD_W-1:0] rsp_item,
   output      logic                     rsp_last
);

   // command and status between the sequencer and the queue datapath
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: decodes request transfers and steps through a drain
   tqi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   // queue stores, counters, drain pointers and the response register
   tqi_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_value  (req_value),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_item   (rsp_item),
      .rsp_last   (rsp_last)
   );

endmodule
`default_nettype wire

/* rtl/tqi_checker.sv */
`default_nettype none
module tqi_checker
   import tqi_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic [ACTION_W-1:0]      req_action,
   input wire logic signed [WORD_W-1:0] req_value,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic [STATUS_W-1:0]      rsp_status,
   input wire logic signed [WORD_W-1:0] rsp_item,
   input wire logic                     rsp_last
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // anything but a merged item is a lone, zero-item response
   a_non_item_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_ITEM) |-> (rsp_item == '0 && rsp_last))
      else $error("non-item response with item or without last");

   // mid-drain the request side is held off
   a_drain_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("request taken during a drain");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_item) && $stable(rsp_last)))
      else $error("stalled response changed");

   // a stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=>
         (req_valid && $stable(req_action) && $stable(req_value)))
      else $error("stalled request changed");

endmodule

bind two_queue_interleaver tqi_checker u_tqi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_action (req_action),
   .req_value  (req_value),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status),
   .rsp_item   (rsp_item),
   .rsp_last   (rsp_last)
);
`default_nettype wire
